>>> rtl/wrtd_pkg.sv
package wrtd_pkg;

    localparam int WORD_W = 16;
    localparam int LEN_W = 16;
    localparam int START_W = 15;
    localparam int LIT_W = 9;
    localparam int TEXEL_COUNT_DEFAULT = 128 * 128;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] LITERAL_MARK = 8'hFF;
    localparam logic [LIT_W-1:0] LITERAL_BASE = LIT_W'(256);

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [LEN_W-1:0]  want;
        logic              last;
    } wrtd_cmd_t;

endpackage

>>> rtl/wrtd_if.sv
interface wrtd_in_if
    import wrtd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;
    logic              last;

    modport source (output valid, output word, output last, input ready);
    modport sink (input valid, input word, input last, output ready);
endinterface

interface wrtd_out_if
    import wrtd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  run_value;
    logic [LEN_W-1:0]   run_length;
    logic [START_W-1:0] start_position;
    logic               overflow;
    logic               end_of_texture;

    modport source (
        output valid, output run_value, output run_length, output start_position,
        output overflow, output end_of_texture, input ready
    );
    modport sink (
        input valid, input run_value, input run_length, input start_position,
        input overflow, input end_of_texture, output ready
    );
endinterface

>>> rtl/wrtd_front.sv
module wrtd_front
    import wrtd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    wrtd_in_if.sink    words,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output wrtd_cmd_t  cmd
);

    typedef enum logic [1:0] {
        PH_CONTROL,
        PH_VALUE,
        PH_LITERAL
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               mode_reg;
    logic [LEN_W-1:0]   repeat_reg, repeat_next;
    logic [LIT_W-1:0]   lit_reg, lit_next, lit_dec;
    logic               accept;

    assign words.ready = cmd_ready;
    assign cmd_valid = words.valid;
    assign accept = words.valid && cmd_ready;
    assign lit_dec = (lit_reg != '0) ? lit_reg - LIT_W'(1) : lit_reg;

    always_comb
    begin
        phase_next = phase_reg;
        repeat_next = repeat_reg;
        lit_next = lit_reg;
        cmd.value = words.word;
        cmd.want = LEN_W'(1);
        cmd.last = words.last;
        if (mode_reg)
        begin
            case (phase_reg)
                PH_VALUE:
                begin
                    cmd.want = repeat_reg;
                    repeat_next = '0;
                    phase_next = PH_CONTROL;
                end
                PH_LITERAL:
                begin
                    lit_next = lit_dec;
                    if (lit_dec == '0)
                    begin
                        phase_next = PH_CONTROL;
                    end
                end
                default:
                begin
                    cmd.value = '0;
                    cmd.want = '0;
                    if (words.word[WORD_W-1:8] == LITERAL_MARK)
                    begin
                        lit_next = LITERAL_BASE - {1'b0, words.word[7:0]};
                        phase_next = PH_LITERAL;
                    end
                    else
                    begin
                        repeat_next = words.word;
                        phase_next = PH_VALUE;
                    end
                end
            endcase
        end
        if (words.last)
        begin
            phase_next = PH_CONTROL;
            repeat_next = '0;
            lit_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CONTROL;
            repeat_reg <= '0;
            lit_reg <= '0;
            mode_reg <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                repeat_reg <= repeat_next;
                lit_reg <= lit_next;
            end
        end
    end

endmodule

>>> rtl/wrtd_queue.sv
module wrtd_queue
    import wrtd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  wrtd_cmd_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output wrtd_cmd_t pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    wrtd_cmd_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign push = push_valid && push_ready;
    assign pop = pop_ready && pop_valid;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/wrtd_back.sv
module wrtd_back
    import wrtd_pkg::*;
#(
    parameter int TEXEL_COUNT = TEXEL_COUNT_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  wrtd_cmd_t cmd,
    wrtd_out_if.source runs
);

    localparam int POS_W = $clog2(TEXEL_COUNT + 1);
    localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam logic [POS_W-1:0] TEXEL_END = POS_W'(TEXEL_COUNT);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   room;
    logic [CMP_W-1:0]   want_ext, room_ext, grant;
    logic               clip;
    logic               take;
    logic               valid_reg;
    logic [WORD_W-1:0]  value_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [START_W-1:0] start_reg;
    logic               overflow_reg;
    logic               eot_reg;

    assign cmd_ready = !valid_reg || runs.ready;
    assign take = cmd_valid && cmd_ready;

    assign room = TEXEL_END - pos_reg;
    assign want_ext = CMP_W'(cmd.want);
    assign room_ext = CMP_W'(room);
    assign clip = (want_ext > room_ext);
    assign grant = clip ? room_ext : want_ext;
    assign pos_next = cmd.last ? '0 : pos_reg + POS_W'(grant);

    assign runs.valid = valid_reg;
    assign runs.run_value = value_reg;
    assign runs.run_length = length_reg;
    assign runs.start_position = start_reg;
    assign runs.overflow = overflow_reg;
    assign runs.end_of_texture = eot_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            value_reg <= cmd.value;
            length_reg <= LEN_W'(grant);
            start_reg <= START_W'(pos_reg);
            overflow_reg <= clip;
            eot_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= 1'b1;
                pos_reg <= pos_next;
            end
            else if (runs.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/word_rle_texture_decoder.sv
// Run-length texture decoder for 16-bit word streams. Every input beat yields one output
// beat describing a run: value, length and start texel; control words give a zero-length
// run. The block takes one word per cycle when not stalled: the front stage decodes the
// control phase, a two-entry command queue registers the command and decouples it from
// the back stage, which clips runs at TEXEL_COUNT, tracks the texel position and registers
// the output. The mode register (reset 1 = compressed) should only be written while idle.
module word_rle_texture_decoder
    import wrtd_pkg::*;
#(
    parameter int TEXEL_COUNT = TEXEL_COUNT_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    wrtd_in_if.sink    words,
    wrtd_out_if.source runs
);

    logic      fq_valid, fq_ready;
    wrtd_cmd_t fq_cmd;
    logic      qb_valid, qb_ready;
    wrtd_cmd_t qb_cmd;

    wrtd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .words       (words),
        .cmd_valid   (fq_valid),
        .cmd_ready   (fq_ready),
        .cmd         (fq_cmd)
    );

    wrtd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_cmd)
    );

    wrtd_back #(
        .TEXEL_COUNT (TEXEL_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .runs      (runs)
    );

endmodule
